/* rtl/hrlp_pkg.sv */
// hrlp_pkg: shared types, codes and helpers of the request line parser
// used by http_request_line_parser_unit and hrlp_checker; no dependencies
`default_nettype none

package hrlp_pkg;

	localparam int unsigned OFFSET_BITS_DEF = 16;
	localparam int unsigned OUT_OFF_BITS    = 16;
	localparam int unsigned RES_BITS        = 104;

	typedef logic [1:0] status_t;
	localparam status_t ST_MORE      = 2'd0;
	localparam status_t ST_DONE      = 2'd1;
	localparam status_t ST_BADMETHOD = 2'd2;
	localparam status_t ST_BADREQ    = 2'd3;

	typedef logic [1:0] method_t;
	localparam method_t MTH_UNKNOWN = 2'd0;
	localparam method_t MTH_GET     = 2'd1;
	localparam method_t MTH_HEAD    = 2'd2;
	localparam method_t MTH_POST    = 2'd3;

	typedef enum logic [14:0] {
		PH_START  = 15'b000000000000001,
		PH_METHOD = 15'b000000000000010,
		PH_SP_URI = 15'b000000000000100,
		PH_URI    = 15'b000000000001000,
		PH_SP_VER = 15'b000000000010000,
		PH_H      = 15'b000000000100000,
		PH_HT     = 15'b000000001000000,
		PH_HTT    = 15'b000000010000000,
		PH_HTTP   = 15'b000000100000000,
		PH_MAJ1   = 15'b000001000000000,
		PH_MAJ    = 15'b000010000000000,
		PH_MIN1   = 15'b000100000000000,
		PH_MIN    = 15'b001000000000000,
		PH_SP_END = 15'b010000000000000,
		PH_CR     = 15'b100000000000000
	} phase_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [31:0] WORD_GET  = 32'h00474554;
	localparam logic [31:0] WORD_HEAD = 32'h48454144;
	localparam logic [31:0] WORD_POST = 32'h504F5354;

	function automatic logic is_method_char(logic [7:0] c);
		return (c >= CH_A && c <= CH_Z) || c == CH_UNDER;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	// acc * 10 + digit, clamped to 255
	function automatic logic [7:0] sat_acc(logic [7:0] acc, logic [3:0] d);
		logic [11:0] v;
		v = (12'(acc) << 3) + (12'(acc) << 1) + 12'(d);
		return (v > 12'd255) ? 8'hFF : v[7:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/http_request_line_parser_unit.sv */
// http_request_line_parser_unit: byte-wise http/1.x request line parser
// depends on hrlp_pkg; checked by hrlp_checker (bound separately)
//
// input stream carries one byte per transaction in s_axis_tdata[7:0];
// s_axis_tuser set means a new request starts with this byte (parser,
// offsets and latched error cleared before it is parsed).
// every input transaction gives exactly one output transaction with the
// status, method, versions and five field offsets seen so far.
// the result is registered: each input byte passes the input register, then
// the parse step into the result register.
// throughput: one byte per cycle while the receiver takes results; the parse
// state update is one short combinational step, so a byte can follow every
// cycle.
// when the receiver stalls, the result register holds and the input
// register fills; s_axis_tready drops once both are occupied.
// reset clears the parse phase, the error, the offset counter, all fields
// and both valid flags. a latched bad method/bad request status repeats
// for every byte until a byte arrives with s_axis_tuser set.
`default_nettype none

module http_request_line_parser_unit
	import hrlp_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [7:0]          s_axis_tdata,  // [7:0] data_byte
	input  wire logic                s_axis_tuser,  // [0] new_request
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// [1:0] status, [3:2] method_code, [11:4] version_major,
	// [19:12] version_minor, [35:20] line_start_offset,
	// [51:36] verb_end_offset, [67:52] target_start_offset,
	// [83:68] target_end_offset, [99:84] line_end_offset, [103:100] zero
	output logic [RES_BITS-1:0]      m_axis_tdata
);

	localparam int unsigned F_LSTART = 0;
	localparam int unsigned F_MEND   = 1;
	localparam int unsigned F_TSTART = 2;
	localparam int unsigned F_TEND   = 3;
	localparam int unsigned F_LEND   = 4;
	localparam int unsigned N_FIELDS = 5;

	typedef logic [OFFSET_BITS-1:0] off_t;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        new_s1;
	logic        adv;

	phase_t      phase_q;
	status_t     err_q;
	off_t        off_q;
	logic [31:0] chars_q;
	logic [2:0]  len_q;
	method_t     kind_q;
	logic [7:0]  maj_q;
	logic [7:0]  min_q;
	off_t        fo_q [N_FIELDS];

	phase_t      phase_n;
	status_t     err_n;
	off_t        off_n;
	logic [31:0] chars_n;
	logic [2:0]  len_n;
	method_t     kind_n;
	logic [7:0]  maj_n;
	logic [7:0]  min_n;
	off_t        fo_n [N_FIELDS];
	status_t     status_n;

	logic                out_valid_q;
	logic [RES_BITS-1:0] out_data_q;
	logic [RES_BITS-1:0] res_n;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		logic [7:0] c;
		off_t       pos;
		c = data_s1;
		if (new_s1) begin
			phase_n = PH_START;
			err_n   = ST_MORE;
			off_n   = '0;
			chars_n = '0;
			len_n   = '0;
			kind_n  = MTH_UNKNOWN;
			maj_n   = '0;
			min_n   = '0;
			for (int i = 0; i < N_FIELDS; i++) fo_n[i] = '0;
		end else begin
			phase_n = phase_q;
			err_n   = err_q;
			off_n   = off_q;
			chars_n = chars_q;
			len_n   = len_q;
			kind_n  = kind_q;
			maj_n   = maj_q;
			min_n   = min_q;
			for (int i = 0; i < N_FIELDS; i++) fo_n[i] = fo_q[i];
		end
		pos      = off_n;
		status_n = ST_MORE;

		if (err_n != ST_MORE) begin
			status_n = err_n;
		end else begin
			unique case (phase_n)
				PH_START: begin
					fo_n[F_LSTART] = pos;
					if (c == CH_CR || c == CH_LF) begin
					end else if (!is_method_char(c)) begin
						status_n = ST_BADMETHOD;
					end else begin
						chars_n = {24'd0, c};
						len_n   = 3'd1;
						kind_n  = MTH_UNKNOWN;
						maj_n   = '0;
						min_n   = '0;
						fo_n[F_MEND]   = '0;
						fo_n[F_TSTART] = '0;
						fo_n[F_TEND]   = '0;
						fo_n[F_LEND]   = '0;
						phase_n = PH_METHOD;
					end
				end
				PH_METHOD: begin
					if (c == CH_SP) begin
						fo_n[F_MEND] = pos;
						if (len_n == 3'd3 && chars_n == WORD_GET)
							kind_n = MTH_GET;
						else if (len_n == 3'd4 && chars_n == WORD_HEAD)
							kind_n = MTH_HEAD;
						else if (len_n == 3'd4 && chars_n == WORD_POST)
							kind_n = MTH_POST;
						else
							kind_n = MTH_UNKNOWN;
						phase_n = PH_SP_URI;
					end else if (!is_method_char(c)) begin
						status_n = ST_BADMETHOD;
					end else begin
						if (len_n < 3'd4) chars_n = {chars_n[23:0], c};
						if (len_n < 3'd7) len_n = len_n + 3'd1;
					end
				end
				PH_SP_URI: begin
					if (c == CH_SLASH) begin
						fo_n[F_TSTART] = pos;
						phase_n = PH_URI;
					end else if (c != CH_SP) begin
						status_n = ST_BADREQ;
					end
				end
				PH_URI: begin
					if (c == CH_SP) begin
						fo_n[F_TEND] = pos;
						phase_n = PH_SP_VER;
					end
				end
				PH_SP_VER: begin
					if (c == CH_H) phase_n = PH_H;
					else if (c != CH_SP) status_n = ST_BADREQ;
				end
				PH_H: begin
					if (c == CH_T) phase_n = PH_HT; else status_n = ST_BADREQ;
				end
				PH_HT: begin
					if (c == CH_T) phase_n = PH_HTT; else status_n = ST_BADREQ;
				end
				PH_HTT: begin
					if (c == CH_P) phase_n = PH_HTTP; else status_n = ST_BADREQ;
				end
				PH_HTTP: begin
					if (c == CH_SLASH) phase_n = PH_MAJ1; else status_n = ST_BADREQ;
				end
				PH_MAJ1: begin
					if (c >= CH_1 && c <= CH_9) begin
						maj_n   = {4'd0, c[3:0]};
						phase_n = PH_MAJ;
					end else begin
						status_n = ST_BADREQ;
					end
				end
				PH_MAJ: begin
					if (c == CH_DOT) phase_n = PH_MIN1;
					else if (is_digit(c)) maj_n = sat_acc(maj_n, c[3:0]);
					else status_n = ST_BADREQ;
				end
				PH_MIN1: begin
					if (is_digit(c)) begin
						min_n   = {4'd0, c[3:0]};
						phase_n = PH_MIN;
					end else begin
						status_n = ST_BADREQ;
					end
				end
				PH_MIN, PH_SP_END: begin
					if (c == CH_CR) begin
						fo_n[F_LEND] = pos;
						phase_n = PH_CR;
					end else if (c == CH_LF) begin
						fo_n[F_LEND] = pos;
						status_n = ST_DONE;
					end else if (c == CH_SP) begin
						phase_n = PH_SP_END;
					end else if (phase_n == PH_MIN && is_digit(c)) begin
						min_n = sat_acc(min_n, c[3:0]);
					end else begin
						status_n = ST_BADREQ;
					end
				end
				PH_CR: begin
					if (c == CH_LF) status_n = ST_DONE; else status_n = ST_BADREQ;
				end
				default: begin
					phase_n  = PH_START;
					status_n = ST_BADREQ;
				end
			endcase

			if (status_n == ST_DONE) phase_n = PH_START;
			else if (status_n != ST_MORE) err_n = status_n;
			off_n = off_n + off_t'(1);
		end

		res_n = {4'd0,
			OUT_OFF_BITS'(fo_n[F_LEND]),
			OUT_OFF_BITS'(fo_n[F_TEND]),
			OUT_OFF_BITS'(fo_n[F_TSTART]),
			OUT_OFF_BITS'(fo_n[F_MEND]),
			OUT_OFF_BITS'(fo_n[F_LSTART]),
			min_n, maj_n, kind_n, status_n};
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			new_s1  <= s_axis_tuser;
		end
	end

	// parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			err_q       <= ST_MORE;
			off_q       <= '0;
			chars_q     <= '0;
			len_q       <= '0;
			kind_q      <= MTH_UNKNOWN;
			maj_q       <= '0;
			min_q       <= '0;
			for (int i = 0; i < N_FIELDS; i++) fo_q[i] <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q <= phase_n;
				err_q   <= err_n;
				off_q   <= off_n;
				chars_q <= chars_n;
				len_q   <= len_n;
				kind_q  <= kind_n;
				maj_q   <= maj_n;
				min_q   <= min_n;
				for (int i = 0; i < N_FIELDS; i++) fo_q[i] <= fo_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_data_q <= res_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/hrlp_checker.sv */
// hrlp_checker: port-level assertions for http_request_line_parser_unit
// depends on hrlp_pkg; attached to the top level by the bind below
`default_nettype none

module hrlp_checker
	import hrlp_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_axis_tvalid,
	input wire logic                s_axis_tready,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	// [1:0] status, [3:2] method_code, [11:4] version_major,
	// [19:12] version_minor, [99:20] offsets, [103:100] zero
	input wire logic [RES_BITS-1:0] m_axis_tdata
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// empty result register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty result register");

	// a complete line always carries a nonzero major version
	a_done_major: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == ST_DONE |-> m_axis_tdata[11:4] != 8'd0)
		else $error("line complete with zero major version");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[103:100] == 4'd0)
		else $error("result padding not zero");

	// a new input can only reach the output after passing through the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !$past(s_axis_tvalid) |=> !m_axis_tvalid)
		else $error("result appeared without an input transaction");

endmodule

bind http_request_line_parser_unit hrlp_checker u_hrlp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
